[src/assert_macros.svh]
// Assertion helpers shared by the servo controller modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CPID_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define CPID_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`define CPID_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`else

`define CPID_ASSERT(lbl, expr, msg)
`define CPID_ASSERT_IMP(lbl, ante, cons, msg)
`define CPID_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[src/cpid_pkg.sv]
package cpid_pkg;

   localparam int PIX_W   = 8;
   localparam int ERR_W   = 9;
   localparam int DERR_W  = 10;
   localparam int INTEG_W = 32;
   localparam int SERVO_W = 11;
   localparam int TOTAL_W = 36;

   localparam logic [SERVO_W-1:0] SERVO_X_MIN = 11'd1350;
   localparam logic [SERVO_W-1:0] SERVO_X_MAX = 11'd1950;
   localparam logic [SERVO_W-1:0] SERVO_Y_MIN = 11'd1400;
   localparam logic [SERVO_W-1:0] SERVO_Y_MAX = 11'd1950;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_POS_KP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POS_KI      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POS_KD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_KP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_KD      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_WINDOW = 3'd7;

   localparam logic [7:0]         RST_POS_KP      = 8'd10;
   localparam logic [3:0]         RST_POS_KI      = 4'd1;
   localparam logic [7:0]         RST_POS_KD      = 8'd100;
   localparam logic [7:0]         RST_VEL_KP      = 8'd12;
   localparam logic [7:0]         RST_VEL_KD      = 8'd8;
   localparam logic [SERVO_W-1:0] RST_CENTER_X    = 11'd1650;
   localparam logic [SERVO_W-1:0] RST_CENTER_Y    = 11'd1675;
   localparam logic [7:0]         RST_STOP_WINDOW = 8'd9;

   typedef struct packed {
      logic [7:0] pos_kp;
      logic [3:0] pos_ki;
      logic [7:0] pos_kd;
      logic [7:0] vel_kp;
      logic [7:0] vel_kd;
   } gains_type;

   // Per-stage load strobes and the integral clear, shared by both axis lanes.
   typedef struct packed {
      logic accept;
      logic clear;
      logic en2;
      logic en3;
   } pipe_ctl_type;

endpackage

[src/dual_axis_cascaded_pid_servo.sv]
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tdata raw/filtered/goal X,Y; tuser stop_enable
// rsp     | out       | rsp_tvalid/rsp_tready | tdata servo_x, servo_y
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// One sample per cycle is accepted unless a stalled result backs the pipeline up.
// The integral, previous errors and positions update in the accept cycle, which is the
// only loop; products, the servo sum and the clamp follow in three pipeline stages.
// Reset is synchronous and restores the gain registers and clears all loop state.
// A stalled result holds the output register while empty stages keep taking samples.
`include "assert_macros.svh"
module dual_axis_cascaded_pid_servo
   import cpid_pkg::*;
#(
   parameter int INTEGRAL_CLEAR_PERIOD = 200
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] raw_x, [15:8] raw_y, [23:16] filtered_x, [31:24] filtered_y,
   // [39:32] goal_x, [47:40] goal_y
   input  logic [47:0]           req_tdata,
   // [0] stop_enable
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [10:0] servo_x, [21:11] servo_y, [23:22] zero
   output logic [23:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(INTEGRAL_CLEAR_PERIOD);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(INTEGRAL_CLEAR_PERIOD - 1);

   // Configuration registers.
   gains_type          gains_ff;
   logic [SERVO_W-1:0] center_x_ff, center_y_ff;
   logic [7:0]         stop_window_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.pos_kp <= RST_POS_KP;
         gains_ff.pos_ki <= RST_POS_KI;
         gains_ff.pos_kd <= RST_POS_KD;
         gains_ff.vel_kp <= RST_VEL_KP;
         gains_ff.vel_kd <= RST_VEL_KD;
         center_x_ff     <= RST_CENTER_X;
         center_y_ff     <= RST_CENTER_Y;
         stop_window_ff  <= RST_STOP_WINDOW;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_POS_KP:      gains_ff.pos_kp <= csr_data[7:0];
            REG_POS_KI:      gains_ff.pos_ki <= csr_data[3:0];
            REG_POS_KD:      gains_ff.pos_kd <= csr_data[7:0];
            REG_VEL_KP:      gains_ff.vel_kp <= csr_data[7:0];
            REG_VEL_KD:      gains_ff.vel_kd <= csr_data[7:0];
            REG_CENTER_X:    center_x_ff     <= csr_data;
            REG_CENTER_Y:    center_y_ff     <= csr_data;
            REG_STOP_WINDOW: stop_window_ff  <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline control: a stage loads when it is empty or its content moves on.
   logic         v1_ff, v2_ff, v3_ff;
   logic         stop1_ff, stop2_ff, stop3_ff;
   logic         en1, en2, en3, en_o;
   logic         accept;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   pipe_ctl_type ctl;

   always_comb begin
      en_o   = !rsp_tvalid || rsp_tready;
      en3    = !v3_ff || en_o;
      en2    = !v2_ff || en3;
      en1    = !v1_ff || en2;
      accept = req_tvalid && en1;
      cnt_in = (cnt_ff == CNT_LAST) ? '0 : cnt_ff + 1'b1;
      ctl.accept = accept;
      // Every period-th sample starts from a cleared integral.
      ctl.clear  = (cnt_ff == CNT_LAST);
      ctl.en2    = en2;
      ctl.en3    = en3;
   end

   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (accept) cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) stop1_ff <= req_tuser;
      if (en2)    stop2_ff <= stop1_ff;
      if (en3)    stop3_ff <= stop2_ff;
   end

   logic signed [TOTAL_W-1:0] total_x, total_y;
   logic signed [ERR_W-1:0]   err_x, err_y;

   cpid_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .gains  (gains_ff),
      .center (center_x_ff),
      .raw    (req_tdata[7:0]),
      .filt   (req_tdata[23:16]),
      .goal   (req_tdata[39:32]),
      .total  (total_x),
      .err    (err_x)
   );

   cpid_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .gains  (gains_ff),
      .center (center_y_ff),
      .raw    (req_tdata[15:8]),
      .filt   (req_tdata[31:24]),
      .goal   (req_tdata[47:40]),
      .total  (total_y),
      .err    (err_y)
   );

   logic [SERVO_W-1:0] servo_x, servo_y;

   cpid_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load_en     (en_o),
      .valid3      (v3_ff),
      .stop3       (stop3_ff),
      .total_x     (total_x),
      .total_y     (total_y),
      .err_x       (err_x),
      .err_y       (err_y),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .stop_window (stop_window_ff),
      .out_valid   (rsp_tvalid),
      .servo_x     (servo_x),
      .servo_y     (servo_y)
   );

   assign rsp_tdata = {2'b00, servo_y, servo_x};

   `CPID_ASSERT(a_cnt_range, cnt_ff <= CNT_LAST, "step counter beyond clear period")
   `CPID_ASSERT_NXT(a_cnt_wrap, accept && (cnt_ff == CNT_LAST), cnt_ff == '0, "step counter did not wrap")
   `CPID_ASSERT_IMP(a_ready_empty, !v1_ff, req_tready, "input stalled with empty first stage")
   `CPID_ASSERT_IMP(a_hold_full, rsp_tvalid && !rsp_tready && v3_ff && v2_ff && v1_ff, !req_tready, "sample accepted into a full pipeline")

endmodule

[src/cpid_lane.sv]
module cpid_lane
   import cpid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  pipe_ctl_type              ctl,
   input  gains_type                 gains,
   input  logic [SERVO_W-1:0]        center,
   input  logic [PIX_W-1:0]          raw,
   input  logic [PIX_W-1:0]          filt,
   input  logic [PIX_W-1:0]          goal,
   output logic signed [TOTAL_W-1:0] total,
   output logic signed [ERR_W-1:0]   err
);

   // Loop state, updated in the accept cycle so the next item sees it at once.
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   perr_ff;
   logic [PIX_W-1:0]          ppos_ff;
   logic signed [ERR_W-1:0]   pverr_ff;

   logic signed [ERR_W-1:0]   err_in;
   logic signed [DERR_W-1:0]  derr_in;
   logic signed [ERR_W-1:0]   verr_in;
   logic signed [DERR_W-1:0]  dverr_in;
   logic signed [INTEG_W-1:0] integ_old;
   logic signed [INTEG_W:0]   isum;
   logic signed [INTEG_W:0]   isum_adj;
   logic signed [INTEG_W-1:0] half;
   logic signed [INTEG_W+4:0] iprod;

   always_comb begin
      err_in    = $signed({1'b0, raw}) - $signed({1'b0, goal});
      derr_in   = {err_in[ERR_W-1], err_in} - {perr_ff[ERR_W-1], perr_ff};
      verr_in   = $signed({1'b0, raw}) - $signed({1'b0, ppos_ff});
      dverr_in  = {verr_in[ERR_W-1], verr_in} - {pverr_ff[ERR_W-1], pverr_ff};
      integ_old = ctl.clear ? '0 : integ_ff;
      isum      = {integ_old[INTEG_W-1], integ_old}
                + {{16{err_in[ERR_W-1]}}, err_in, 8'b0};
      // Halving by the shift floors, so negative sums are bumped first to round toward zero.
      isum_adj  = isum + {{INTEG_W{1'b0}}, isum[INTEG_W]};
      half      = isum_adj[INTEG_W:1];
      iprod     = half * $signed({1'b0, gains.pos_ki});
      if ((iprod[INTEG_W+4:INTEG_W-1] == '0) || (iprod[INTEG_W+4:INTEG_W-1] == '1)) begin
         integ_in = iprod[INTEG_W-1:0];
      end else if (iprod[INTEG_W+4]) begin
         integ_in = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         integ_in = {1'b0, {(INTEG_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         perr_ff  <= '0;
         ppos_ff  <= '0;
         pverr_ff <= '0;
      end else if (ctl.accept) begin
         integ_ff <= integ_in;
         perr_ff  <= err_in;
         ppos_ff  <= filt;
         pverr_ff <= verr_in;
      end
   end

   // Stage 1: errors and the fresh integral.
   logic signed [ERR_W-1:0]   err1_ff;
   logic signed [DERR_W-1:0]  derr1_ff;
   logic signed [ERR_W-1:0]   verr1_ff;
   logic signed [DERR_W-1:0]  dverr1_ff;
   logic signed [INTEG_W-1:0] integ1_ff;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         err1_ff   <= err_in;
         derr1_ff  <= derr_in;
         verr1_ff  <= verr_in;
         dverr1_ff <= dverr_in;
         integ1_ff <= integ_in;
      end
   end

   // Stage 2: the four gain products.
   logic signed [17:0]        pp_in, vp_in;
   logic signed [18:0]        pd_in, vd_in;
   logic signed [17:0]        pp2_ff, vp2_ff;
   logic signed [18:0]        pd2_ff, vd2_ff;
   logic signed [INTEG_W-1:0] integ2_ff;
   logic signed [ERR_W-1:0]   err2_ff;

   always_comb begin
      pp_in = $signed({1'b0, gains.pos_kp}) * err1_ff;
      pd_in = $signed({1'b0, gains.pos_kd}) * derr1_ff;
      vp_in = $signed({1'b0, gains.vel_kp}) * verr1_ff;
      vd_in = $signed({1'b0, gains.vel_kd}) * dverr1_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         pp2_ff    <= pp_in;
         pd2_ff    <= pd_in;
         vp2_ff    <= vp_in;
         vd2_ff    <= vd_in;
         integ2_ff <= integ1_ff;
         err2_ff   <= err1_ff;
      end
   end

   // Stage 3: center minus four times the velocity term minus the position terms, Q.8.
   logic signed [19:0]        vel;
   logic signed [TOTAL_W-1:0] total_in;
   logic signed [TOTAL_W-1:0] total3_ff;
   logic signed [ERR_W-1:0]   err3_ff;

   always_comb begin
      vel      = 20'(vp2_ff) - 20'(vd2_ff);
      total_in = $signed({17'b0, center, 8'b0})
               - (TOTAL_W'(vel) <<< 10)
               - (TOTAL_W'(pp2_ff) <<< 8)
               - TOTAL_W'(integ2_ff)
               - (TOTAL_W'(pd2_ff) <<< 8);
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         total3_ff <= total_in;
         err3_ff   <= err2_ff;
      end
   end

   assign total = total3_ff;
   assign err   = err3_ff;

endmodule

[src/cpid_merge.sv]
`include "assert_macros.svh"
module cpid_merge
   import cpid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_en,
   input  logic                      valid3,
   input  logic                      stop3,
   input  logic signed [TOTAL_W-1:0] total_x,
   input  logic signed [TOTAL_W-1:0] total_y,
   input  logic signed [ERR_W-1:0]   err_x,
   input  logic signed [ERR_W-1:0]   err_y,
   input  logic [SERVO_W-1:0]        center_x,
   input  logic [SERVO_W-1:0]        center_y,
   input  logic [7:0]                stop_window,
   output logic                      out_valid,
   output logic [SERVO_W-1:0]        servo_x,
   output logic [SERVO_W-1:0]        servo_y
);

   function automatic logic [SERVO_W-1:0] servo_clamp(input logic signed [TOTAL_W-1:0] t,
                                                      input logic [SERVO_W-1:0] lo,
                                                      input logic [SERVO_W-1:0] hi);
      logic signed [TOTAL_W-1:0] lo_q;
      logic signed [TOTAL_W-1:0] hi_q;
      logic [SERVO_W-1:0]        r;
      lo_q = $signed({17'b0, lo, 8'b0});
      hi_q = $signed({17'b0, hi, 8'b0});
      // Inside the limits the sum is positive, so dropping the fraction truncates toward zero.
      if (t >= hi_q) begin
         r = hi;
      end else if (t <= lo_q) begin
         r = lo;
      end else begin
         r = t[SERVO_W+7:8];
      end
      return r;
   endfunction

   logic signed [ERR_W:0] win;
   logic signed [ERR_W:0] ex, ey;
   logic                  near;
   logic [SERVO_W-1:0]    sx_in, sy_in;

   always_comb begin
      win   = $signed({2'b0, stop_window});
      ex    = {err_x[ERR_W-1], err_x};
      ey    = {err_y[ERR_W-1], err_y};
      near  = (ex <= win) && (-ex <= win) && (ey <= win) && (-ey <= win);
      if (stop3 && near) begin
         sx_in = center_x;
         sy_in = center_y;
      end else begin
         sx_in = servo_clamp(total_x, SERVO_X_MIN, SERVO_X_MAX);
         sy_in = servo_clamp(total_y, SERVO_Y_MIN, SERVO_Y_MAX);
      end
   end

   logic               valid_ff;
   logic [SERVO_W-1:0] sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_en) begin
         valid_ff <= valid3;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && valid3) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
   end

   assign out_valid = valid_ff;
   assign servo_x   = sx_ff;
   assign servo_y   = sy_ff;

   `CPID_ASSERT_IMP(a_servo_x_range, valid_ff, ((sx_ff >= SERVO_X_MIN) && (sx_ff <= SERVO_X_MAX)) || (sx_ff == center_x), "servo_x outside limits")
   `CPID_ASSERT_IMP(a_servo_y_range, valid_ff, ((sy_ff >= SERVO_Y_MIN) && (sy_ff <= SERVO_Y_MAX)) || (sy_ff == center_y), "servo_y outside limits")

endmodule
